### design/one_shot_timer_task_pool_top_defines.svh
// ----------------------------------------------------------------------------
// One-shot timer task pool: assertion macros
// Clocked property checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_TASK_POOL_TOP_DEFINES_SVH
`define ONE_SHOT_TIMER_TASK_POOL_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define OTP_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OTP_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTP_ASSERT_RST(label, clk, rst, prop, msg)
`define OTP_ASSERT(label, clk, prop, msg)
`endif

`endif

### design/otp_pkg.sv
// ----------------------------------------------------------------------------
// One-shot timer task pool: package
// Field widths, operation and result codes, slot entry type.
// ----------------------------------------------------------------------------
package otp_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

   localparam int OPCODE_W = 2;
   localparam int DELAY_W  = 16;
   localparam int HANDLE_W = 8;
   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 3;

   localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;

   typedef struct packed {
      logic [DELAY_W-1:0]  countdown;
      logic [HANDLE_W-1:0] handle;
   } slot_entry_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

endpackage

### design/otp_if.sv
// ----------------------------------------------------------------------------
// One-shot timer task pool: channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface otp_req_if import otp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [DELAY_W-1:0]  delay_ticks;
   logic [HANDLE_W-1:0] task_handle;

   modport source (output valid, opcode, delay_ticks, task_handle, input ready);
   modport sink   (input valid, opcode, delay_ticks, task_handle, output ready);
endinterface

interface otp_rsp_if import otp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [SLOT_W-1:0]   slot_index;
   logic [HANDLE_W-1:0] fired_handle;
   logic                last_of_run;

   modport source (output valid, result_kind, slot_index, fired_handle, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, slot_index, fired_handle, last_of_run,
                   output ready);
endinterface

### design/otp_store.sv
// ----------------------------------------------------------------------------
// One-shot timer task pool: slot store
// Countdown and handle memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module otp_store import otp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_entry_type   rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  slot_entry_type   wr_data
);

   slot_entry_type mem_ff [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/otp_seq.sv
// ----------------------------------------------------------------------------
// One-shot timer task pool: slot sequencer
// Walks the slots one per cycle while no result stalls, runs the shared
// decrement and compare unit, keeps busy and ready bits and drives the result register.
// ----------------------------------------------------------------------------
`include "one_shot_timer_task_pool_top_defines.svh"

module otp_seq import otp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   otp_req_if.sink           req_ch,
   otp_rsp_if.source         rsp_ch,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  slot_entry_type    rd_data,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_addr,
   output slot_entry_type    wr_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type           state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   logic                issue_ff, issue_in;
   logic                pv_ff, pv_in;
   logic [NRES_W-1:0]   nres_ff, nres_in;
   logic [SLOTS-1:0]    busy_ff, busy_in;
   logic [SLOTS-1:0]    ready_ff, ready_in;

   logic                out_v_ff, out_v_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [HANDLE_W-1:0] fired_ff, fired_in;
   logic                last_ff, last_in;

   logic                emit;
   logic [KIND_W-1:0]   e_kind;
   logic [SLOT_W-1:0]   e_slot;
   logic [HANDLE_W-1:0] e_handle;
   logic                e_last;
   logic                finish;
   logic                stall;
   logic                out_load;
   logic                last_slot;
   logic                ready_above;
   logic [SLOTS-1:0]    ready_shift;
   logic [DELAY_W-1:0]  dec;

   assign last_slot   = (pidx_ff == LAST_IDX);
   assign ready_shift = ready_ff >> pidx_ff;
   assign ready_above = |(ready_shift >> 1);
   assign dec         = rd_data.countdown - 1'b1;

   // result for the slot in the execute stage
   always_comb begin
      emit     = 1'b0;
      e_kind   = KIND_ACCEPTED;
      e_slot   = SLOT_W'(pidx_ff);
      e_handle = '0;
      e_last   = 1'b0;
      finish   = 1'b0;
      if (pv_ff) begin
         unique case (op_ff)
            OP_ADD: begin
               if (!busy_ff[pidx_ff]) begin
                  emit   = 1'b1;
                  e_last = 1'b1;
                  finish = 1'b1;
               end else if (last_slot) begin
                  emit   = 1'b1;
                  e_kind = KIND_REJECTED;
                  e_slot = '0;
                  e_last = 1'b1;
                  finish = 1'b1;
               end
            end
            OP_TICK: begin
               finish = last_slot;
            end
            OP_DISPATCH: begin
               if (ready_ff[pidx_ff]) begin
                  emit     = 1'b1;
                  e_kind   = KIND_FIRED;
                  e_handle = rd_data.handle;
                  e_last   = (nres_ff == NRES_W'(MAX_RESULTS - 1)) || !ready_above;
               end
               finish = e_last || last_slot;
            end
            default: begin
               finish = 1'b1;
            end
         endcase
      end
   end

   assign stall    = emit && out_v_ff && !rsp_ch.ready;
   assign out_load = emit && !stall;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      delay_in  = delay_ff;
      handle_in = handle_ff;
      idx_in    = idx_ff;
      pidx_in   = pidx_ff;
      issue_in  = issue_ff;
      pv_in     = pv_ff;
      nres_in   = nres_ff;
      busy_in   = busy_ff;
      ready_in  = ready_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = pidx_ff;
      wr_data   = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.opcode;
               delay_in  = req_ch.delay_ticks;
               handle_in = req_ch.task_handle;
               idx_in    = '0;
               issue_in  = 1'b1;
               pv_in     = 1'b0;
               nres_in   = '0;
               if (req_ch.opcode != OP_NONE) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!stall) begin
               rd_en   = issue_ff;
               pv_in   = issue_ff;
               pidx_in = idx_ff;
               if (issue_ff) begin
                  if (idx_ff == LAST_IDX) begin
                     issue_in = 1'b0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               if (pv_ff) begin
                  unique case (op_ff)
                     OP_ADD: begin
                        if (!busy_ff[pidx_ff]) begin
                           wr_en             = 1'b1;
                           wr_data.countdown = delay_ff;
                           wr_data.handle    = handle_ff;
                           busy_in[pidx_ff]  = 1'b1;
                           ready_in[pidx_ff] = 1'b0;
                        end
                     end
                     OP_TICK: begin
                        if (busy_ff[pidx_ff] && (rd_data.countdown != '0)) begin
                           wr_en             = 1'b1;
                           wr_data.countdown = dec;
                           if (dec == '0) begin
                              ready_in[pidx_ff] = 1'b1;
                           end
                        end
                     end
                     OP_DISPATCH: begin
                        if (ready_ff[pidx_ff]) begin
                           ready_in[pidx_ff] = 1'b0;
                           busy_in[pidx_ff]  = 1'b0;
                           nres_in           = nres_ff + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (finish) begin
                  state_in = S_IDLE;
                  issue_in = 1'b0;
                  pv_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_v_in = out_v_ff;
      kind_in  = kind_ff;
      slot_in  = slot_ff;
      fired_in = fired_ff;
      last_in  = last_ff;
      if (out_v_ff && rsp_ch.ready) begin
         out_v_in = 1'b0;
      end
      if (out_load) begin
         out_v_in = 1'b1;
         kind_in  = e_kind;
         slot_in  = e_slot;
         fired_in = e_handle;
         last_in  = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
         nres_ff  <= '0;
         busy_ff  <= '0;
         ready_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pv_ff    <= pv_in;
         nres_ff  <= nres_in;
         busy_ff  <= busy_in;
         ready_ff <= ready_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      delay_ff  <= delay_in;
      handle_ff <= handle_in;
      idx_ff    <= idx_in;
      pidx_ff   <= pidx_in;
      kind_ff   <= kind_in;
      slot_ff   <= slot_in;
      fired_ff  <= fired_in;
      last_ff   <= last_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.result_kind  = kind_ff;
   assign rsp_ch.slot_index   = slot_ff;
   assign rsp_ch.fired_handle = fired_ff;
   assign rsp_ch.last_of_run  = last_ff;

   `OTP_ASSERT_RST(a_ready_is_busy, clock, reset, (ready_ff & ~busy_ff) == '0, "ready slot not busy")
   `OTP_ASSERT_RST(a_item_starts_scan, clock, reset, req_ch.valid && req_ch.ready && (req_ch.opcode != OP_NONE) |=> state_ff == S_SCAN, "item did not start a scan")
   `OTP_ASSERT_RST(a_no_overwrite, clock, reset, out_load |-> (!out_v_ff || rsp_ch.ready), "result register overwritten")
   `OTP_ASSERT_RST(a_stall_holds_slot, clock, reset, stall |=> $stable(pidx_ff) && pv_ff, "execute stage moved on stall")
   `OTP_ASSERT_RST(a_fire_limit, clock, reset, nres_ff <= NRES_W'(MAX_RESULTS), "too many fired results")
   `OTP_ASSERT(a_reset_idle, clock, reset |=> (state_ff == S_IDLE) && !rsp_ch.valid, "not idle after reset")

endmodule

### design/one_shot_timer_task_pool_top.sv
// ----------------------------------------------------------------------------
// One-shot timer task pool: top level
// Pool of SLOTS one-shot countdown timers with add, tick and dispatch items.
// ----------------------------------------------------------------------------
// Each request item is worked by a scan that visits one slot per cycle, unless
// a result stalls, through the slot memory and a single decrement and compare
// unit; req_ch.ready is low for the whole scan. A tick scans every slot, an add
// that claims slot k ends its scan at that slot and a rejected add scans every
// slot. A dispatch ends after the last slot that it fires, or after the last
// slot when no slot is ready. An add or a dispatch also waits for as long as
// one of its results finds the result register full. Opcode 3 is taken and
// ignored. A dispatch fires at most eight slots, lowest first, and the rest
// stay ready for a later dispatch. The result register lets a new item be
// taken while the last result waits on rsp_ch.
module one_shot_timer_task_pool_top import otp_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   otp_req_if.sink   req_ch,
   otp_rsp_if.source rsp_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   slot_entry_type   rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_entry_type   wr_data;

   otp_seq #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   otp_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

### bench/tb_one_shot_timer_task_pool_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-shot timer task pool: testbench
// Drives add, tick and dispatch items into the pool and predicts every result
// from its own copy of the slot table. Results are checked field by field, in
// order, while both channels idle and stall at random across several phases.
// ----------------------------------------------------------------------------
module tb_one_shot_timer_task_pool_top;
   import otp_pkg::*;

   localparam int POOL_SLOTS  = 8;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 4 * (POOL_SLOTS + 2);
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 58;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [SLOT_W-1:0]   slot_index;
      logic [HANDLE_W-1:0] fired_handle;
      logic                last_of_run;
   } timer_result_type;

   class timer_pool_scoreboard;
      logic                slot_busy  [POOL_SLOTS];
      logic                slot_ready [POOL_SLOTS];
      logic [DELAY_W-1:0]  slot_count [POOL_SLOTS];
      logic [HANDLE_W-1:0] slot_owner [POOL_SLOTS];
      timer_result_type    due_results[$];
      int                  mismatch_count;

      function new();
         for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_ready[i] = 1'b0;
            slot_count[i] = '0;
            slot_owner[i] = '0;
         end
         mismatch_count = 0;
      endfunction

      function void push_due(logic [KIND_W-1:0] kind, int slot, logic [HANDLE_W-1:0] handle,
                             logic last);
         timer_result_type r;
         r.result_kind  = kind;
         r.slot_index   = SLOT_W'(slot);
         r.fired_handle = handle;
         r.last_of_run  = last;
         due_results.push_back(r);
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [DELAY_W-1:0] delay,
                                 logic [HANDLE_W-1:0] handle);
         int free_slot;
         int ready_total;
         int fired;
         free_slot   = -1;
         ready_total = 0;
         fired       = 0;
         case (op)
            OP_ADD: begin
               for (int i = POOL_SLOTS - 1; i >= 0; i--)
                  if (!slot_busy[i]) free_slot = i;
               if (free_slot < 0) begin
                  push_due(KIND_REJECTED, 0, '0, 1'b1);
               end else begin
                  slot_busy[free_slot]  = 1'b1;
                  slot_ready[free_slot] = 1'b0;
                  slot_count[free_slot] = delay;
                  slot_owner[free_slot] = handle;
                  push_due(KIND_ACCEPTED, free_slot, '0, 1'b1);
               end
            end
            OP_TICK: begin
               for (int i = 0; i < POOL_SLOTS; i++) begin
                  if (slot_count[i] != '0) begin
                     slot_count[i] = slot_count[i] - 1'b1;
                     if (slot_count[i] == '0) slot_ready[i] = 1'b1;
                  end
               end
            end
            OP_DISPATCH: begin
               for (int i = 0; i < POOL_SLOTS; i++)
                  if (slot_ready[i]) ready_total++;
               if (ready_total > MAX_RESULTS) ready_total = MAX_RESULTS;
               for (int i = 0; i < POOL_SLOTS && fired < ready_total; i++) begin
                  if (slot_ready[i]) begin
                     fired++;
                     push_due(KIND_FIRED, i, slot_owner[i], fired == ready_total);
                     slot_ready[i] = 1'b0;
                     slot_busy[i]  = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(timer_result_type got);
         timer_result_type want;
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] unexpected result: kind=%0d slot=%0d handle=%02h last=%0b",
                        $time, got.result_kind, got.slot_index, got.fired_handle,
                        got.last_of_run);
            return;
         end
         want = due_results.pop_front();
         if (got.result_kind !== want.result_kind || got.slot_index !== want.slot_index ||
             got.fired_handle !== want.fired_handle || got.last_of_run !== want.last_of_run)
         begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] result mismatch: ", $time,
                        "expected kind=%0d slot=%0d handle=%02h last=%0b, ",
                        want.result_kind, want.slot_index, want.fired_handle,
                        want.last_of_run,
                        "got kind=%0d slot=%0d handle=%02h last=%0b",
                        got.result_kind, got.slot_index, got.fired_handle,
                        got.last_of_run);
         end
      endfunction

      function int pending_count();
         return due_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   otp_req_if req_bus ();
   otp_rsp_if rsp_bus ();

   timer_pool_scoreboard pool_sb = new();

   int send_idle_pct      = 0;
   int recv_stall_pct     = 0;
   bit recv_hold_request  = 1'b0;
   int recv_hold_left     = 0;
   int cycle_count        = 0;

   one_shot_timer_task_pool_top #(.SLOTS(POOL_SLOTS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            pool_sb.check_result('{rsp_bus.result_kind, rsp_bus.slot_index,
                                   rsp_bus.fired_handle, rsp_bus.last_of_run});
         if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (recv_hold_request) begin
            recv_hold_request = 1'b0;
            recv_hold_left    = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(logic [OPCODE_W-1:0] op, logic [DELAY_W-1:0] delay,
                            logic [HANDLE_W-1:0] handle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.delay_ticks <= delay;
      req_bus.task_handle <= handle;
      do @(posedge clock); while (!req_bus.ready);
      pool_sb.note_request(op, delay, handle);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pool_sb.pending_count() != 0);
   endtask

   task automatic send_random_items(int count);
      int                 sent;
      int                 pick;
      logic [DELAY_W-1:0] delay;
      sent = 0;
      while (sent < count) begin
         pick  = $urandom_range(99);
         delay = ($urandom_range(9) == 0) ? DELAY_W'($urandom_range(60, 7))
                                          : DELAY_W'($urandom_range(6, 1));
         if (pick < 4) begin
            send_item(OP_NONE, DELAY_W'($urandom), HANDLE_W'($urandom));
         end else begin
            if (pick < 40)
               send_item(OP_ADD, delay, HANDLE_W'($urandom));
            else if (pick < 80)
               send_item(OP_TICK, DELAY_W'($urandom), HANDLE_W'($urandom));
            else
               send_item(OP_DISPATCH, DELAY_W'($urandom), HANDLE_W'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_NONE;
      req_bus.delay_ticks <= '0;
      req_bus.task_handle <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pool, ignored opcode, then fill every slot
      send_item(OP_DISPATCH, 16'h0000, 8'h00);
      send_item(OP_NONE, 16'hFFFF, 8'hFF);
      send_item(OP_ADD, 16'h0000, 8'h00);
      send_item(OP_ADD, 16'hFFFF, 8'hFF);
      send_item(OP_ADD, 16'h0001, 8'h80);
      send_item(OP_ADD, 16'h0002, 8'h01);
      send_item(OP_ADD, 16'h0001, 8'h5A);
      send_item(OP_ADD, 16'h0003, 8'hA5);
      send_item(OP_ADD, 16'h0002, 8'h3C);
      send_item(OP_ADD, 16'h0001, 8'hC3);
      send_item(OP_ADD, 16'h0005, 8'h11);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_ADD, 16'h0004, 8'h22);
      send_item(OP_DISPATCH, 16'h0000, 8'h00);
      send_item(OP_TICK, 16'hFFFF, 8'hFF);
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_DISPATCH, 16'h0000, 8'h00);
      // every usable slot ready at once
      for (int i = 0; i < POOL_SLOTS - 2; i++)
         send_item(OP_ADD, 16'h0001, HANDLE_W'(8'hE0 + i));
      send_item(OP_TICK, 16'h0000, 8'h00);
      send_item(OP_DISPATCH, 16'h0000, 8'h00);
      drain_results();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_items(PHASE_ITEMS);
      drain_results();

      send_idle_pct  = 70;
      recv_stall_pct = 0;
      send_random_items(PHASE_ITEMS);
      drain_results();

      // hold the receiver off while items keep coming
      send_idle_pct     = 0;
      recv_stall_pct    = 70;
      recv_hold_request = 1'b1;
      send_random_items(PHASE_ITEMS);
      drain_results();

      send_idle_pct  = 11;
      recv_stall_pct = 11;
      send_random_items(PHASE_ITEMS);
      drain_results();

      repeat (SETTLE) @(posedge clock);
      if (pool_sb.mismatch_count == 0 && pool_sb.pending_count() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/otp_pkg.sv
design/otp_if.sv
design/otp_store.sv
design/otp_seq.sv
design/one_shot_timer_task_pool_top.sv
bench/tb_one_shot_timer_task_pool_top.sv
